[hw/rtl/matrix3_inverse_defines.svh]
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX3_INVERSE_DEFINES_SVH
`define MATRIX3_INVERSE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled in reset.
`define M3INV_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled in reset.
`define M3INV_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/m3inv_pkg.sv]
// Constants for the 3x3 matrix inverse: element count and cofactor index tables.
package m3inv_pkg;

  localparam int unsigned NUM_ELEM = 9;

  // Cofactor i is a[COF_IDX[i][0]]*a[COF_IDX[i][1]] - a[COF_IDX[i][2]]*a[COF_IDX[i][3]],
  // already transposed so that it is the adjugate element i in row-major order.
  localparam int unsigned COF_IDX [NUM_ELEM][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 8, 1}, '{1, 5, 4, 2},
    '{5, 6, 8, 3}, '{0, 8, 6, 2}, '{2, 3, 5, 0},
    '{3, 7, 6, 4}, '{1, 6, 7, 0}, '{0, 4, 3, 1}
  };

  // First-row expansion of the determinant: a0*c0 + a1*c3 + a2*c6.
  localparam int unsigned DET_COF [3] = '{0, 3, 6};

endpackage

[hw/rtl/m3inv_ifs.sv]
// Valid/ready channel interfaces for the matrix and inverse items.
interface m3inv_in_if #(
  parameter int unsigned ELEM_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [ELEM_BITS-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, input ready);
  modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22, output ready);
endinterface

interface m3inv_out_if #(
  parameter int unsigned ELEM_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [ELEM_BITS-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
  logic signed [ELEM_BITS-1:0] det_value;
  logic                        ok;
  logic                        saturated;

  modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  det_value, ok, saturated, input ready);
  modport sink   (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  det_value, ok, saturated, output ready);
endinterface

[hw/rtl/matrix3_inverse.sv]
// Pipelined 3x3 fixed-point matrix inverse by adjugate and determinant.
//
// Takes one 3x3 matrix of signed fixed-point elements (ELEM_BITS wide, FRAC_BITS
// fraction bits, Q16.16 by default) per item and returns its inverse together with
// the determinant. The block accepts one item in every clock cycle as long as results
// are taken. After an input register, stages form the cofactor products, the cofactors,
// the determinant (split into half-width partial products), the magnitudes and the
// scaled dividends; then comes a restoring divider that resolves one quotient bit per
// stage, ELEM_BITS + 1 stages deep and nine lanes wide; a last stage saturates and
// signs the result into the output register. Each stage carries its own valid bit
// and only holds when it is full and the stage after it cannot take its contents, so
// bubbles close up and the input stays ready while a finished result waits to be
// taken, as long as any stage is empty. Inverse elements are the
// exact cofactor divided by the exact determinant, rounded to nearest with ties away
// from zero, and clipped to the element range; the determinant is reported rounded
// and clipped the same way, and saturated is raised if anything was clipped. When
// the exact determinant is zero, ok is low, the input matrix is returned unchanged,
// and det_value and saturated are zero. A tiny determinant that rounds to zero still
// yields ok high and an inverse taken from the exact value.
`include "matrix3_inverse_defines.svh"

module matrix3_inverse #(
  parameter int unsigned ELEM_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  m3inv_in_if.sink     mat_i,
  m3inv_out_if.source  inv_o
);

  localparam int unsigned E   = ELEM_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned NE  = m3inv_pkg::NUM_ELEM;
  localparam int unsigned PW  = 2 * E;             // cofactor product
  localparam int unsigned CW  = 2 * E + 1;         // cofactor, signed
  localparam int unsigned HW  = 2 * E + 1;         // determinant partial product
  localparam int unsigned DW  = 3 * E + 1;         // determinant, signed
  localparam int unsigned AW  = 2 * E;             // cofactor magnitude
  localparam int unsigned ADW = 3 * E;             // determinant magnitude
  localparam int unsigned RW  = 4 * E + 2 * F + 3; // dividend and remainder
  localparam int unsigned QW  = E + 1;             // quotient
  localparam int unsigned ND  = E + 1;             // divider stages
  localparam int unsigned NS  = E + 9;             // all stages, output included

  typedef struct packed {
    logic            zero;
    logic            dsat;
    logic [E-1:0]    detv;
    logic [NE-1:0]   neg;
    logic [RW-1:0]   d;
  } sb_t;

  // Stage enables and valid bits.
  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || inv_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign mat_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= mat_i.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // The input matrix travels alongside for the singular case.
  logic signed [E-1:0] a_in [NE];
  logic signed [E-1:0] a_q  [NS-1][NE];

  assign a_in[0] = mat_i.a00;
  assign a_in[1] = mat_i.a01;
  assign a_in[2] = mat_i.a02;
  assign a_in[3] = mat_i.a10;
  assign a_in[4] = mat_i.a11;
  assign a_in[5] = mat_i.a12;
  assign a_in[6] = mat_i.a20;
  assign a_in[7] = mat_i.a21;
  assign a_in[8] = mat_i.a22;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q[0] <= a_in;
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) begin
        a_q[k] <= a_q[k-1];
      end
    end
  end

  // Stage 1: the two products of each cofactor.
  logic signed [PW-1:0] p1_d [NE][2];
  logic signed [PW-1:0] p1_q [NE][2];

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      p1_d[i][0] = a_q[0][m3inv_pkg::COF_IDX[i][0]] * a_q[0][m3inv_pkg::COF_IDX[i][1]];
      p1_d[i][1] = a_q[0][m3inv_pkg::COF_IDX[i][2]] * a_q[0][m3inv_pkg::COF_IDX[i][3]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      p1_q <= p1_d;
    end
  end

  // Stage 2: cofactors.
  logic signed [CW-1:0] c2_d [NE];
  logic signed [CW-1:0] c2_q [NE];

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      c2_d[i] = CW'(p1_q[i][0]) - CW'(p1_q[i][1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      c2_q <= c2_d;
    end
  end

  // Stage 3: first-row products, each split into a low and a high half of the cofactor.
  logic signed [HW-1:0] plo3_d [3];
  logic signed [HW-1:0] phi3_d [3];
  logic signed [HW-1:0] plo3_q [3];
  logic signed [HW-1:0] phi3_q [3];
  logic signed [CW-1:0] c3_q   [NE];

  always_comb begin
    logic [CW-1:0] c;
    for (int t = 0; t < 3; t++) begin
      c = c2_q[m3inv_pkg::DET_COF[t]];
      plo3_d[t] = a_q[2][t] * $signed({1'b0, c[E-1:0]});
      phi3_d[t] = a_q[2][t] * $signed(c[CW-1:E]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      plo3_q <= plo3_d;
      phi3_q <= phi3_d;
      c3_q   <= c2_q;
    end
  end

  // Stage 4: determinant.
  logic signed [DW-1:0] det4_d;
  logic signed [DW-1:0] det4_q;
  logic signed [CW-1:0] c4_q [NE];

  always_comb begin
    logic signed [DW-1:0] hi;
    logic signed [DW-1:0] lo;
    det4_d = '0;
    for (int t = 0; t < 3; t++) begin
      hi = phi3_q[t];
      lo = plo3_q[t];
      det4_d = det4_d + (hi <<< E) + lo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      det4_q <= det4_d;
      c4_q   <= c3_q;
    end
  end

  // Stage 5: magnitudes and quotient signs.
  logic [AW-1:0]  an5_d [NE];
  logic [AW-1:0]  an5_q [NE];
  logic [ADW-1:0] ad5_d, ad5_q;
  logic [NE-1:0]  neg5_d, neg5_q;
  logic           dneg5_q, zero5_q;

  always_comb begin
    logic [DW-1:0] dabs;
    logic [CW-1:0] cabs;
    dabs  = det4_q[DW-1] ? DW'(-det4_q) : DW'(det4_q);
    ad5_d = dabs[ADW-1:0];
    for (int i = 0; i < NE; i++) begin
      cabs      = c4_q[i][CW-1] ? CW'(-c4_q[i]) : CW'(c4_q[i]);
      an5_d[i]  = cabs[AW-1:0];
      neg5_d[i] = c4_q[i][CW-1] ^ det4_q[DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      an5_q   <= an5_d;
      ad5_q   <= ad5_d;
      neg5_q  <= neg5_d;
      dneg5_q <= det4_q[DW-1];
      zero5_q <= (det4_q == '0);
    end
  end

  // Stage 6: dividends 2*|c|*2^(2F) + |det| over divisor 2*|det|, and the rounded
  // determinant.
  logic [RW-1:0] n6_d [NE];
  logic [RW-1:0] n6_q [NE];
  sb_t           sb6_d;
  sb_t           sb_q [ND+1];

  always_comb begin
    logic [ADW-1:0] adq;
    logic [ADW-1:0] dlim;
    logic [ADW-1:0] dm;
    logic [ADW-1:0] dv;
    for (int i = 0; i < NE; i++) begin
      n6_d[i] = (RW'(an5_q[i]) << (2 * F + 1)) + RW'(ad5_q);
    end
    adq  = (ad5_q + (ADW'(1) << (2 * F - 1))) >> (2 * F);
    dlim = dneg5_q ? (ADW'(1) << (E - 1)) : ((ADW'(1) << (E - 1)) - ADW'(1));
    dm   = (adq > dlim) ? dlim : adq;
    dv   = dneg5_q ? ADW'(-dm) : dm;
    sb6_d.zero = zero5_q;
    sb6_d.dsat = (adq > dlim);
    sb6_d.detv = dv[E-1:0];
    sb6_d.neg  = neg5_q;
    sb6_d.d    = RW'(ad5_q) << 1;
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      n6_q     <= n6_d;
      sb_q[0]  <= sb6_d;
    end
  end

  // Divider: stage j decides quotient bit ELEM_BITS - j in every lane.
  logic [RW-1:0] r_q   [ND][NE];
  logic [QW-1:0] q_q   [ND][NE];
  logic [NE-1:0] big_q [ND];

  for (genvar j = 0; j < ND; j++) begin : g_div
    localparam int unsigned K = E - j;
    logic [RW-1:0] rin  [NE];
    logic [QW-1:0] qin  [NE];
    logic [NE-1:0] bin;
    logic [RW-1:0] r_d  [NE];
    logic [QW-1:0] q_d  [NE];

    if (j == 0) begin : g_first
      // Quotients of 2^(ELEM_BITS+1) or more are beyond any representable result.
      always_comb begin
        for (int i = 0; i < NE; i++) begin
          rin[i] = n6_q[i];
          qin[i] = '0;
          bin[i] = (n6_q[i] >= (sb_q[0].d << (E + 1)));
        end
      end
    end else begin : g_rest
      always_comb begin
        for (int i = 0; i < NE; i++) begin
          rin[i] = r_q[j-1][i];
          qin[i] = q_q[j-1][i];
        end
        bin = big_q[j-1];
      end
    end

    always_comb begin
      logic [RW-1:0] dsh;
      logic          ge;
      dsh = sb_q[j].d << K;
      for (int i = 0; i < NE; i++) begin
        ge       = (rin[i] >= dsh);
        r_d[i]   = ge ? (rin[i] - dsh) : rin[i];
        q_d[i]   = qin[i];
        q_d[i][K] = ge;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[7+j]) begin
        r_q[j]    <= r_d;
        q_q[j]    <= q_d;
        big_q[j]  <= bin;
        sb_q[j+1] <= sb_q[j];
      end
    end
  end

  // Output stage: clip, apply sign, or pass the input through when singular.
  logic [E-1:0] b_d [NE];
  logic [E-1:0] b_q [NE];
  logic [E-1:0] det_d, det_q;
  logic         ok_d, ok_q;
  logic         sat_d, sat_q;

  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] mag;
    logic [QW-1:0] sv;
    logic          es;
    sb_t           sb;
    sb    = sb_q[ND];
    sat_d = sb.dsat;
    for (int i = 0; i < NE; i++) begin
      lim   = sb.neg[i] ? (QW'(1) << (E - 1)) : ((QW'(1) << (E - 1)) - QW'(1));
      es    = big_q[ND-1][i] || (q_q[ND-1][i] > lim);
      mag   = es ? lim : q_q[ND-1][i];
      sv    = sb.neg[i] ? QW'(-mag) : mag;
      sat_d = sat_d || es;
      b_d[i] = sv[E-1:0];
    end
    det_d = sb.detv;
    ok_d  = 1'b1;
    if (sb.zero) begin
      for (int i = 0; i < NE; i++) begin
        b_d[i] = a_q[NS-2][i];
      end
      det_d = '0;
      ok_d  = 1'b0;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      b_q   <= b_d;
      det_q <= det_d;
      ok_q  <= ok_d;
      sat_q <= sat_d;
    end
  end

  assign inv_o.valid     = v_q[NS-1];
  assign inv_o.b00       = b_q[0];
  assign inv_o.b01       = b_q[1];
  assign inv_o.b02       = b_q[2];
  assign inv_o.b10       = b_q[3];
  assign inv_o.b11       = b_q[4];
  assign inv_o.b12       = b_q[5];
  assign inv_o.b20       = b_q[6];
  assign inv_o.b21       = b_q[7];
  assign inv_o.b22       = b_q[8];
  assign inv_o.det_value = det_q;
  assign inv_o.ok        = ok_q;
  assign inv_o.saturated = sat_q;

  // An empty first stage must always be able to take an item.
  `M3INV_ASSERT_IMP(a_ready_when_empty, !v_q[0], mat_i.ready, "input stalled with empty first stage")
  // An accepted item occupies the first stage on the next cycle.
  `M3INV_ASSERT_NXT(a_accept_lands, mat_i.valid && mat_i.ready, v_q[0], "accepted item was lost")
  // A singular result reports a zero determinant and no clipping.
  `M3INV_ASSERT_IMP(a_singular_clean, inv_o.valid && !inv_o.ok, (inv_o.det_value == '0) && !inv_o.saturated, "singular result carries determinant or saturation")

endmodule
